// ----- hdl/box_stack_max_height_macros.svh -----
// assertion macros for the box stack block
`ifndef BOX_STACK_MAX_HEIGHT_MACROS_SVH
`define BOX_STACK_MAX_HEIGHT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSMH_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bsmh check failed");

// next-cycle implication, checked outside reset
`define BSMH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bsmh check failed");

`endif

// ----- hdl/bsmh_pkg.sv -----
// package: sizes and controller/datapath interface types for the box stack block
package bsmh_pkg;
    localparam int MAX_BOXES  = 32;
    localparam int ORIENTS    = 6;
    localparam int DEPTH      = MAX_BOXES * ORIENTS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DIM_W      = 16;
    localparam int HEIGHT_W   = 24;
    localparam int ORI_W      = 3;
    localparam logic [ORI_W-1:0] ORI_LAST = ORI_W'(ORIENTS - 1);

    typedef struct packed {
        logic accept;     // latch input beat
        logic drop;       // box does not fit
        logic start_ins;  // load key for next orientation
        logic shift;      // move entry up one place
        logic place;      // write key, bump count
        logic dp_start;   // clear dp index and best height
        logic dp_fetch;   // read entry i
        logic dp_head;    // capture entry i
        logic dp_step;    // compare against entry j
        logic dp_write;   // store best for entry i
        logic emit;       // load result register, clear set
    } bsmh_cmd_t;

    typedef struct packed {
        logic fits;
        logic in_last;
        logic last;
        logic cnt_zero;
        logic ahead;
        logic pos_one;
        logic ori_last;
        logic i_done;
        logic i_zero;
        logic j_last;
        logic out_free;
    } bsmh_sts_t;
endpackage

// ----- hdl/bsmh_dp.sv -----
// datapath: orientation store, insertion shifter, chain dp and result register
module bsmh_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bsmh_pkg::DIM_W-1:0]    s_dim_a,
    input  logic [bsmh_pkg::DIM_W-1:0]    s_dim_b,
    input  logic [bsmh_pkg::DIM_W-1:0]    s_dim_c,
    input  logic                          s_last_box,
    input  bsmh_pkg::bsmh_cmd_t           cmd,
    output bsmh_pkg::bsmh_sts_t           sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bsmh_pkg::HEIGHT_W-1:0] m_max_height,
    output logic                          m_overflowed
);
    localparam int DW = bsmh_pkg::DIM_W;
    localparam int HW = bsmh_pkg::HEIGHT_W;
    localparam int AW = bsmh_pkg::ADDR_W;
    localparam int CW = bsmh_pkg::CNT_W;

    logic [3*DW-1:0] orient_mem [bsmh_pkg::DEPTH];
    logic [HW-1:0]   best_mem   [bsmh_pkg::DEPTH];

    logic [DW-1:0]      a_reg, b_reg, c_reg;
    logic               last_reg;
    logic [bsmh_pkg::ORI_W-1:0] ori_reg;
    logic [CW-1:0]      count_reg, pos_reg, i_reg, j_reg;
    logic               dropped_reg;
    logic [DW-1:0]      key_l_reg, key_w_reg, key_h_reg;
    logic [HW-1:0]      cur_reg, best_all_reg;
    logic [3*DW-1:0]    rd_orient_reg;
    logic [HW-1:0]      rd_best_reg;
    logic               m_valid_reg;
    logic [HW-1:0]      out_h_reg;
    logic               out_ovf_reg;

    logic [DW-1:0] perm_l, perm_w, perm_h;
    logic [DW-1:0] rd_l, rd_w, rd_h;
    logic [CW-1:0] raddr;
    logic [HW:0]   cand_sum;
    logic [HW-1:0] cand;
    logic          fits_j;

    assign rd_l = rd_orient_reg[3*DW-1:2*DW];
    assign rd_w = rd_orient_reg[2*DW-1:DW];
    assign rd_h = rd_orient_reg[DW-1:0];

    always_comb begin
        case (ori_reg)
            3'd0: begin perm_l = a_reg; perm_w = b_reg; perm_h = c_reg; end
            3'd1: begin perm_l = a_reg; perm_w = c_reg; perm_h = b_reg; end
            3'd2: begin perm_l = b_reg; perm_w = a_reg; perm_h = c_reg; end
            3'd3: begin perm_l = b_reg; perm_w = c_reg; perm_h = a_reg; end
            3'd4: begin perm_l = c_reg; perm_w = a_reg; perm_h = b_reg; end
            default: begin perm_l = c_reg; perm_w = b_reg; perm_h = a_reg; end
        endcase
    end

    // read address for the registered store read
    always_comb begin
        raddr = '0;
        if (cmd.start_ins) begin
            raddr = count_reg - CW'(1);
        end else if (cmd.shift) begin
            raddr = pos_reg - CW'(2);
        end else if (cmd.dp_fetch) begin
            raddr = i_reg;
        end else if (cmd.dp_step) begin
            raddr = j_reg + CW'(1);
        end
    end

    assign cand_sum = {1'b0, rd_best_reg} + (HW+1)'(key_h_reg);
    assign cand     = cand_sum[HW] ? {HW{1'b1}} : cand_sum[HW-1:0];
    assign fits_j   = (key_l_reg < rd_l) && (key_w_reg < rd_w);

    always_ff @(posedge aclk) begin
        rd_orient_reg <= orient_mem[raddr[AW-1:0]];
        rd_best_reg   <= best_mem[raddr[AW-1:0]];
        if (cmd.shift) begin
            orient_mem[pos_reg[AW-1:0]] <= rd_orient_reg;
        end else if (cmd.place) begin
            orient_mem[pos_reg[AW-1:0]] <= {key_l_reg, key_w_reg, key_h_reg};
        end
        if (cmd.dp_write) begin
            best_mem[i_reg[AW-1:0]] <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            a_reg    <= s_dim_a;
            b_reg    <= s_dim_b;
            c_reg    <= s_dim_c;
            last_reg <= s_last_box;
        end
        if (cmd.start_ins) begin
            key_l_reg <= perm_l;
            key_w_reg <= perm_w;
            key_h_reg <= perm_h;
            pos_reg   <= count_reg;
        end else if (cmd.shift) begin
            pos_reg <= pos_reg - CW'(1);
        end else if (cmd.dp_head) begin
            key_l_reg <= rd_l;
            key_w_reg <= rd_w;
            key_h_reg <= rd_h;
        end
        if (cmd.dp_head) begin
            cur_reg <= HW'(rd_h);
            j_reg   <= '0;
        end else if (cmd.dp_step) begin
            if (fits_j && cand > cur_reg) begin
                cur_reg <= cand;
            end
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.dp_start) begin
            i_reg        <= '0;
            best_all_reg <= '0;
        end else if (cmd.dp_write) begin
            i_reg <= i_reg + CW'(1);
            if (cur_reg > best_all_reg) begin
                best_all_reg <= cur_reg;
            end
        end
        if (cmd.emit) begin
            out_h_reg   <= best_all_reg;
            out_ovf_reg <= dropped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            ori_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                ori_reg <= '0;
            end else if (cmd.place) begin
                ori_reg <= ori_reg + bsmh_pkg::ORI_W'(1);
            end
            if (cmd.emit) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else begin
                if (cmd.place) begin
                    count_reg <= count_reg + CW'(1);
                end
                if (cmd.drop) begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.fits     = ({1'b0, count_reg} + (CW+1)'(bsmh_pkg::ORIENTS))
                       <= (CW+1)'(bsmh_pkg::DEPTH);
        sts.in_last  = s_last_box;
        sts.last     = last_reg;
        sts.cnt_zero = (count_reg == '0);
        // sorts ahead: longer base, or same length and wider
        sts.ahead    = (key_l_reg > rd_l) || ((key_l_reg == rd_l) && (key_w_reg > rd_w));
        sts.pos_one  = (pos_reg == CW'(1));
        sts.ori_last = (ori_reg == bsmh_pkg::ORI_LAST);
        sts.i_done   = (i_reg == count_reg);
        sts.i_zero   = (i_reg == '0);
        sts.j_last   = ((j_reg + CW'(1)) == i_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_max_height = out_h_reg;
    assign m_overflowed = out_ovf_reg;
endmodule

// ----- hdl/bsmh_ctrl.sv -----
// controller: sequences insertion of orientations and the chain dp
module bsmh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bsmh_pkg::bsmh_sts_t sts,
    output bsmh_pkg::bsmh_cmd_t cmd
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_LOAD  = 8'b00000010,
        ST_CMP   = 8'b00000100,
        ST_PLACE = 8'b00001000,
        ST_DPI   = 8'b00010000,
        ST_DPH   = 8'b00100000,
        ST_DPJ   = 8'b01000000,
        ST_DPW   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (sts.fits) begin
                        state_next = ST_LOAD;
                    end else begin
                        cmd.drop = 1'b1;
                        if (sts.in_last) begin
                            cmd.dp_start = 1'b1;
                            state_next   = ST_DPI;
                        end
                    end
                end
            end
            ST_LOAD: begin
                cmd.start_ins = 1'b1;
                state_next    = sts.cnt_zero ? ST_PLACE : ST_CMP;
            end
            ST_CMP: begin
                if (sts.ahead) begin
                    cmd.shift  = 1'b1;
                    state_next = sts.pos_one ? ST_PLACE : ST_CMP;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.place = 1'b1;
                if (!sts.ori_last) begin
                    state_next = ST_LOAD;
                end else if (sts.last) begin
                    cmd.dp_start = 1'b1;
                    state_next   = ST_DPI;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DPI: begin
                if (!sts.i_done) begin
                    cmd.dp_fetch = 1'b1;
                    state_next   = ST_DPH;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DPH: begin
                cmd.dp_head = 1'b1;
                state_next  = sts.i_zero ? ST_DPW : ST_DPJ;
            end
            ST_DPJ: begin
                cmd.dp_step = 1'b1;
                state_next  = sts.j_last ? ST_DPW : ST_DPJ;
            end
            ST_DPW: begin
                cmd.dp_write = 1'b1;
                state_next   = ST_DPI;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- hdl/box_stack_max_height.sv -----
// top level: tallest box stack, controller plus datapath
//
//  channel  ports                                 direction  beat meaning
//  s_       s_dim_a/b/c, s_last_box, valid/ready  in         one box
//  m_       m_max_height, m_overflowed            out        one result per set
//
// each box that fits is accepted, then its six orientations are inserted into a sorted
// store through the registered store read; an orientation loads its key, then
// compares and shifts past each entry it sorts ahead of, and is placed, with no
// compare when the store is empty or once it reaches the front
// after the last box the chain dp runs over the n stored orientations,
// one compare-add per cycle on the shared store read
// reset is synchronous active low and clears only control state
// a held result stalls only the end of the next set's dp, not box intake
`include "box_stack_max_height_macros.svh"

module box_stack_max_height (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bsmh_pkg::DIM_W-1:0]    s_dim_a,
    input  logic [bsmh_pkg::DIM_W-1:0]    s_dim_b,
    input  logic [bsmh_pkg::DIM_W-1:0]    s_dim_c,
    input  logic                          s_last_box,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bsmh_pkg::HEIGHT_W-1:0] m_max_height,
    output logic                          m_overflowed
);
    bsmh_pkg::bsmh_cmd_t cmd;
    bsmh_pkg::bsmh_sts_t sts;

    // sequencer
    bsmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // store, dp arithmetic and result register
    bsmh_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_dim_a      (s_dim_a),
        .s_dim_b      (s_dim_b),
        .s_dim_c      (s_dim_c),
        .s_last_box   (s_last_box),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_max_height (m_max_height),
        .m_overflowed (m_overflowed)
    );

    // a held result is never overwritten by a new one
    `BSMH_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free)
    // a box that fits closes the input as its insertion starts
    `BSMH_ASSERT_NEXT(a_busy_after_fit, aclk, aresetn, s_valid && s_ready && sts.fits, !s_ready)
    // a box that is not last never produces a result straight away
    `BSMH_ASSERT_NEXT(a_no_early_result, aclk, aresetn,
        s_valid && s_ready && !s_last_box, !cmd.emit)
endmodule
